### rtl/c8ic_pkg.sv
package c8ic_pkg;

  // memory geometry (fixed)
  localparam int unsigned MEM_AW = 12;

  // reset values
  localparam logic [11:0] PC_RESET   = 12'h200;
  localparam logic [15:0] SEED_RESET = 16'd44257;
  localparam logic [15:0] LFSR_TAPS  = 16'hB400;

  // request types
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_STEP = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // special opcodes
  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  // ALU group low nibbles
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_RSB = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  // key group codes
  localparam logic [7:0] KEY_DOWN = 8'h9E;
  localparam logic [7:0] KEY_UP   = 8'hA1;

  // misc group codes
  localparam logic [7:0] FN_GET_DT = 8'h07;
  localparam logic [7:0] FN_WAITK  = 8'h0A;
  localparam logic [7:0] FN_SET_DT = 8'h15;
  localparam logic [7:0] FN_SET_ST = 8'h18;
  localparam logic [7:0] FN_ADD_I  = 8'h1E;
  localparam logic [7:0] FN_FONT   = 8'h29;
  localparam logic [7:0] FN_BCD    = 8'h33;
  localparam logic [7:0] FN_STORE  = 8'h55;
  localparam logic [7:0] FN_LOAD   = 8'h65;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_PIX, S_FHI, S_FLO, S_RDX, S_RDY, S_EXEC, S_WRVF, S_RET,
    S_BCD, S_STRD, S_STWR, S_LDRD, S_LDWR, S_DROW, S_DLOAD, S_DPIX, S_DXOR
  } state_e;

endpackage

### rtl/c8ic_ram.sv
module c8ic_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/chip8_instruction_core_unit.sv
// Channel   Direction  Signals                                   Handshake
// request   in         req_type_i address_i load_byte_i keys_down_i  start & !busy
// result    out        program_counter_o pixel_value_o display_changed_o
//                      beep_o waiting_for_key_o opcode_error_o   done_o, one cycle
// config    in         cfg_wdata_i                               cfg_we_i
//
// Load, unused-type and halted step requests finish in S_IDLE, pixel reads in S_PIX.
// A step runs through fetch and register-read states (S_FHI, S_FLO, S_RDX, S_RDY)
// before S_EXEC; flag ALU ops, 00EE, FX55/FX65, FX33, DXYN and 00E0 go on
// through further states of their own.
// After reset a clearing pass sweeps every pixel of the frame
// memory with busy high. Results cannot be stalled by the receiver.
module chip8_instruction_core_unit #(
  parameter int unsigned SCREEN_W    = 64,
  parameter int unsigned SCREEN_H    = 32,
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [11:0] address_i,
  input  logic [7:0]  load_byte_i,
  input  logic [15:0] keys_down_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        done_o,
  output logic [11:0] program_counter_o,
  output logic        pixel_value_o,
  output logic        display_changed_o,
  output logic        beep_o,
  output logic        waiting_for_key_o,
  output logic        opcode_error_o
);

  import c8ic_pkg::*;

  localparam int unsigned PIXELS = SCREEN_W * SCREEN_H;
  localparam int unsigned PB     = $clog2(PIXELS);
  localparam int unsigned SPW    = $clog2(STACK_DEPTH);
  localparam logic [8:0]  W9     = 9'(SCREEN_W);
  localparam logic [8:0]  H9     = 9'(SCREEN_H);

  // reduce an 8-bit value below m (m >= 32)
  function automatic logic [7:0] mod_by(input logic [7:0] v, input logic [8:0] m);
    logic [7:0] r;
    r = v;
    for (int k = 0; k < 7; k++) begin
      if ({1'b0, r} >= m) r = r - m[7:0];
    end
    return r;
  endfunction

  state_e state_q, state_d;
  logic [11:0] pc_q, pc_d;
  logic [15:0] idx_q, idx_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [7:0] dly_q, dly_d, snd_q, snd_d;
  logic [15:0] lfsr_q, lfsr_d;
  logic halt_q, halt_d;
  logic clr_step_q, clr_step_d;
  logic [PB-1:0] clr_q, clr_d;
  logic [15:0] regv_q, regv_d;
  logic [STACK_DEPTH-1:0] stkv_q, stkv_d;

  // payload registers
  logic [15:0] op_q, op_d;
  logic [7:0]  ophi_q, ophi_d;
  logic [7:0]  vx_q, vx_d, vy_q, vy_d, x0_q, x0_d, y0_q, y0_d, row_q, row_d;
  logic [15:0] keys_q, keys_d;
  logic [3:0]  i_q, i_d, col_q, col_d;
  logic        hit_q, hit_d, flag_q, flag_d, pix_ok_q, pix_ok_d;
  logic [PB-1:0] p_q, p_d;
  logic [3:0]  rraddr_q;
  logic [SPW-1:0] sraddr_q;

  // result registers
  logic done_q;
  logic [11:0] res_pc_q;
  logic res_pix_q, res_chg_q, res_beep_q, res_wait_q, res_err_q;

  // memory ports
  logic mem_we;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [7:0] mem_wdata, mem_rdata;
  logic reg_we;
  logic [3:0] reg_waddr, reg_raddr;
  logic [7:0] reg_wdata, reg_rdata;
  logic fb_we;
  logic [PB-1:0] fb_waddr, fb_raddr;
  logic fb_wdata, fb_rdata;
  logic stk_we;
  logic [SPW-1:0] stk_waddr, stk_raddr;
  logic [11:0] stk_wdata, stk_rdata;

  c8ic_ram #(.WIDTH(8), .DEPTH(1 << MEM_AW)) u_main_mem (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata),
    .raddr_i(mem_raddr), .rdata_o(mem_rdata)
  );

  c8ic_ram #(.WIDTH(8), .DEPTH(16)) u_reg_mem (
    .clk_i, .we_i(reg_we), .waddr_i(reg_waddr), .wdata_i(reg_wdata),
    .raddr_i(reg_raddr), .rdata_o(reg_rdata)
  );

  c8ic_ram #(.WIDTH(1), .DEPTH(PIXELS)) u_frame_mem (
    .clk_i, .we_i(fb_we), .waddr_i(fb_waddr), .wdata_i(fb_wdata),
    .raddr_i(fb_raddr), .rdata_o(fb_rdata)
  );

  c8ic_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack_mem (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  // never-written registers and stack slots read as zero
  logic [7:0]  rv;
  logic [11:0] sv;
  assign rv = regv_q[rraddr_q] ? reg_rdata : 8'd0;
  assign sv = stkv_q[sraddr_q] ? stk_rdata : 12'd0;

  // decode helpers
  logic [3:0]  op_x, op_n;
  logic [7:0]  op_nn;
  logic [11:0] op_nnn, pc2, pc4, ia;
  logic [SPW-1:0] sp_inc, sp_dec;
  logic [15:0] lfsr_nx;
  assign op_x   = op_q[11:8];
  assign op_n   = op_q[3:0];
  assign op_nn  = op_q[7:0];
  assign op_nnn = op_q[11:0];
  assign pc2    = pc_q + 12'd2;
  assign pc4    = pc_q + 12'd4;
  assign ia     = idx_q[11:0] + {8'd0, i_q};
  assign sp_inc = (sp_q == SPW'(STACK_DEPTH - 1)) ? '0 : sp_q + 1'b1;
  assign sp_dec = (sp_q == '0) ? SPW'(STACK_DEPTH - 1) : sp_q - 1'b1;
  assign lfsr_nx = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? LFSR_TAPS : 16'd0);

  // lowest pressed key
  logic [3:0] low_key;
  always_comb begin
    low_key = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (keys_q[k]) low_key = 4'(k);
    end
  end

  // decimal digits of VX
  logic [6:0]  bcd_r;
  logic [7:0]  bcd_h;
  logic [14:0] bcd_prod;
  logic [3:0]  bcd_t, bcd_o;
  logic [7:0]  bcd_dig;
  always_comb begin
    if (vx_q >= 8'd200) begin
      bcd_h = 8'd2;
      bcd_r = 7'(vx_q - 8'd200);
    end else if (vx_q >= 8'd100) begin
      bcd_h = 8'd1;
      bcd_r = 7'(vx_q - 8'd100);
    end else begin
      bcd_h = 8'd0;
      bcd_r = vx_q[6:0];
    end
    bcd_prod = {8'd0, bcd_r} * 15'd205;
    bcd_t    = bcd_prod[14:11];
    bcd_o    = 4'(bcd_r - ({3'd0, bcd_t} * 7'd10));
    unique case (i_q[1:0])
      2'd0:    bcd_dig = bcd_h;
      2'd1:    bcd_dig = {4'd0, bcd_t};
      default: bcd_dig = {4'd0, bcd_o};
    endcase
  end

  // sprite pixel address with wrap
  logic [8:0] ysum, xsum;
  logic [7:0] py, px;
  logic [PB-1:0] p_calc;
  always_comb begin
    ysum = {1'b0, y0_q} + {5'd0, i_q};
    xsum = {1'b0, x0_q} + {5'd0, col_q};
    py = (ysum >= H9) ? 8'(ysum - H9) : ysum[7:0];
    px = (xsum >= W9) ? 8'(xsum - W9) : xsum[7:0];
    p_calc = PB'(PB'(py) * PB'(SCREEN_W) + PB'(px));
  end

  // sequencer
  logic fin, fin_step, set_dt, set_st;
  logic res_pix, res_chg, res_wait, res_beep;
  logic [7:0] dly_base, snd_base;
  logic [8:0] alu_sum;

  always_comb begin
    state_d = state_q;   pc_d = pc_q;     idx_d = idx_q;   sp_d = sp_q;
    lfsr_d = lfsr_q;     halt_d = halt_q; clr_step_d = clr_step_q;
    clr_d = clr_q;       regv_d = regv_q; stkv_d = stkv_q;
    op_d = op_q;         ophi_d = ophi_q; vx_d = vx_q;     vy_d = vy_q;
    x0_d = x0_q;         y0_d = y0_q;     row_d = row_q;   keys_d = keys_q;
    i_d = i_q;           col_d = col_q;   hit_d = hit_q;   flag_d = flag_q;
    pix_ok_d = pix_ok_q; p_d = p_q;
    mem_we = 1'b0; mem_waddr = ia; mem_wdata = 8'd0; mem_raddr = pc_q;
    reg_we = 1'b0; reg_waddr = op_x; reg_wdata = 8'd0; reg_raddr = op_x;
    fb_we = 1'b0;  fb_waddr = p_q;   fb_wdata = 1'b0;  fb_raddr = p_q;
    stk_we = 1'b0; stk_waddr = sp_q; stk_wdata = pc_q; stk_raddr = sp_q;
    fin = 1'b0; fin_step = 1'b0; set_dt = 1'b0; set_st = 1'b0;
    res_pix = 1'b0; res_chg = 1'b0; res_wait = 1'b0;
    alu_sum = 9'd0;

    unique case (state_q)
      S_CLR: begin
        fb_we = 1'b1;
        fb_waddr = clr_q;
        if (clr_q == PB'(PIXELS - 1)) begin
          if (clr_step_q) begin
            pc_d = pc2;
            res_chg = 1'b1;
            fin_step = 1'b1;
          end else begin
            state_d = S_IDLE;
          end
          clr_step_d = 1'b0;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          keys_d = keys_down_i;
          unique case (req_type_i)
            REQ_LOAD: begin
              mem_we = 1'b1;
              mem_waddr = address_i;
              mem_wdata = load_byte_i;
              fin = 1'b1;
            end
            REQ_STEP: begin
              if (halt_q) begin
                fin = 1'b1;
              end else begin
                mem_raddr = pc_q;
                state_d = S_FHI;
              end
            end
            REQ_READ: begin
              fb_raddr = PB'(address_i);
              pix_ok_d = {20'd0, address_i} < PIXELS;
              state_d = S_PIX;
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_PIX: begin
        res_pix = pix_ok_q & fb_rdata;
        fin = 1'b1;
      end
      S_FHI: begin
        ophi_d = mem_rdata;
        mem_raddr = pc_q + 12'd1;
        state_d = S_FLO;
      end
      S_FLO: begin
        op_d = {ophi_q, mem_rdata};
        reg_raddr = ophi_q[3:0];
        state_d = S_RDX;
      end
      S_RDX: begin
        vx_d = rv;
        reg_raddr = (op_q[15:12] == 4'hB) ? 4'd0 : op_q[7:4];
        state_d = S_RDY;
      end
      S_RDY: begin
        vy_d = rv;
        x0_d = mod_by(vx_q, W9);
        y0_d = mod_by(rv, H9);
        state_d = S_EXEC;
      end
      S_EXEC: begin
        unique case (op_q[15:12])
          4'h0: begin
            if (op_q == OP_CLS) begin
              clr_d = '0;
              clr_step_d = 1'b1;
              state_d = S_CLR;
            end else if (op_q == OP_RET) begin
              sp_d = sp_dec;
              stk_raddr = sp_dec;
              state_d = S_RET;
            end else begin
              halt_d = 1'b1;
              fin_step = 1'b1;
            end
          end
          4'h1: begin
            pc_d = op_nnn;
            fin_step = 1'b1;
          end
          4'h2: begin
            stk_we = 1'b1;
            stkv_d[sp_q] = 1'b1;
            sp_d = sp_inc;
            pc_d = op_nnn;
            fin_step = 1'b1;
          end
          4'h3: begin
            pc_d = (vx_q == op_nn) ? pc4 : pc2;
            fin_step = 1'b1;
          end
          4'h4: begin
            pc_d = (vx_q != op_nn) ? pc4 : pc2;
            fin_step = 1'b1;
          end
          4'h5: begin
            pc_d = (vx_q == vy_q) ? pc4 : pc2;
            fin_step = 1'b1;
          end
          4'h6: begin
            reg_we = 1'b1;
            reg_wdata = op_nn;
            pc_d = pc2;
            fin_step = 1'b1;
          end
          4'h7: begin
            reg_we = 1'b1;
            reg_wdata = vx_q + op_nn;
            pc_d = pc2;
            fin_step = 1'b1;
          end
          4'h8: begin
            // plain ops finish here, flag ops write VF next cycle
            state_d = S_WRVF;
            unique case (op_n)
              ALU_MOV: begin reg_we = 1'b1; reg_wdata = vy_q; end
              ALU_OR:  begin reg_we = 1'b1; reg_wdata = vx_q | vy_q; end
              ALU_AND: begin reg_we = 1'b1; reg_wdata = vx_q & vy_q; end
              ALU_XOR: begin reg_we = 1'b1; reg_wdata = vx_q ^ vy_q; end
              ALU_ADD: begin
                alu_sum = {1'b0, vx_q} + {1'b0, vy_q};
                reg_we = 1'b1;
                reg_wdata = alu_sum[7:0];
                flag_d = alu_sum[8];
              end
              ALU_SUB: begin
                reg_we = 1'b1;
                reg_wdata = vx_q - vy_q;
                flag_d = vx_q >= vy_q;
              end
              ALU_SHR: begin
                reg_we = 1'b1;
                reg_wdata = {1'b0, vx_q[7:1]};
                flag_d = vx_q[0];
              end
              ALU_RSB: begin
                reg_we = 1'b1;
                reg_wdata = vy_q - vx_q;
                flag_d = vy_q >= vx_q;
              end
              ALU_SHL: begin
                reg_we = 1'b1;
                reg_wdata = {vx_q[6:0], 1'b0};
                flag_d = vx_q[7];
              end
              default: begin
                halt_d = 1'b1;
                fin_step = 1'b1;
              end
            endcase
            if (op_n == ALU_MOV || op_n == ALU_OR || op_n == ALU_AND || op_n == ALU_XOR) begin
              pc_d = pc2;
              fin_step = 1'b1;
            end
          end
          4'h9: begin
            pc_d = (vx_q != vy_q) ? pc4 : pc2;
            fin_step = 1'b1;
          end
          4'hA: begin
            idx_d = {4'd0, op_nnn};
            pc_d = pc2;
            fin_step = 1'b1;
          end
          4'hB: begin
            pc_d = op_nnn + {4'd0, vy_q};
            fin_step = 1'b1;
          end
          4'hC: begin
            lfsr_d = lfsr_nx;
            reg_we = 1'b1;
            reg_wdata = lfsr_nx[7:0] & op_nn;
            pc_d = pc2;
            fin_step = 1'b1;
          end
          4'hD: begin
            i_d = 4'd0;
            hit_d = 1'b0;
            state_d = S_DROW;
          end
          4'hE: begin
            fin_step = 1'b1;
            if (op_nn == KEY_DOWN) begin
              pc_d = keys_q[vx_q[3:0]] ? pc4 : pc2;
            end else if (op_nn == KEY_UP) begin
              pc_d = keys_q[vx_q[3:0]] ? pc2 : pc4;
            end else begin
              halt_d = 1'b1;
            end
          end
          default: begin
            fin_step = 1'b1;
            pc_d = pc2;
            unique case (op_nn)
              FN_GET_DT: begin reg_we = 1'b1; reg_wdata = dly_q; end
              FN_WAITK: begin
                if (keys_q == 16'd0) begin
                  res_wait = 1'b1;
                  pc_d = pc_q;
                end else begin
                  reg_we = 1'b1;
                  reg_wdata = {4'd0, low_key};
                end
              end
              FN_SET_DT: set_dt = 1'b1;
              FN_SET_ST: set_st = 1'b1;
              FN_ADD_I:  idx_d = idx_q + {8'd0, vx_q};
              FN_FONT:   idx_d = 16'({4'd0, vx_q[3:0]} * 8'd5);
              FN_BCD: begin
                fin_step = 1'b0;
                pc_d = pc_q;
                i_d = 4'd0;
                state_d = S_BCD;
              end
              FN_STORE: begin
                fin_step = 1'b0;
                pc_d = pc_q;
                i_d = 4'd0;
                state_d = S_STRD;
              end
              FN_LOAD: begin
                fin_step = 1'b0;
                pc_d = pc_q;
                i_d = 4'd0;
                state_d = S_LDRD;
              end
              default: begin
                halt_d = 1'b1;
                pc_d = pc_q;
              end
            endcase
          end
        endcase
      end
      S_WRVF: begin
        reg_we = 1'b1;
        reg_waddr = 4'hF;
        reg_wdata = {7'd0, flag_q};
        pc_d = pc2;
        fin_step = 1'b1;
      end
      S_RET: begin
        pc_d = sv + 12'd2;
        fin_step = 1'b1;
      end
      S_BCD: begin
        mem_we = 1'b1;
        mem_wdata = bcd_dig;
        if (i_q == 4'd2) begin
          pc_d = pc2;
          fin_step = 1'b1;
        end else begin
          i_d = i_q + 4'd1;
        end
      end
      S_STRD: begin
        reg_raddr = i_q;
        state_d = S_STWR;
      end
      S_STWR: begin
        mem_we = 1'b1;
        mem_wdata = rv;
        if (i_q == op_x) begin
          pc_d = pc2;
          fin_step = 1'b1;
        end else begin
          i_d = i_q + 4'd1;
          state_d = S_STRD;
        end
      end
      S_LDRD: begin
        mem_raddr = ia;
        state_d = S_LDWR;
      end
      S_LDWR: begin
        reg_we = 1'b1;
        reg_waddr = i_q;
        reg_wdata = mem_rdata;
        if (i_q == op_x) begin
          pc_d = pc2;
          fin_step = 1'b1;
        end else begin
          i_d = i_q + 4'd1;
          state_d = S_LDRD;
        end
      end
      S_DROW: begin
        if (i_q == op_n) begin
          reg_we = 1'b1;
          reg_waddr = 4'hF;
          reg_wdata = {7'd0, hit_q};
          res_chg = 1'b1;
          pc_d = pc2;
          fin_step = 1'b1;
        end else begin
          mem_raddr = ia;
          state_d = S_DLOAD;
        end
      end
      S_DLOAD: begin
        row_d = mem_rdata;
        col_d = 4'd0;
        state_d = S_DPIX;
      end
      S_DPIX: begin
        if (col_q[3]) begin
          i_d = i_q + 4'd1;
          state_d = S_DROW;
        end else if (row_q[3'd7 - col_q[2:0]]) begin
          p_d = p_calc;
          fb_raddr = p_calc;
          state_d = S_DXOR;
        end else begin
          col_d = col_q + 4'd1;
        end
      end
      S_DXOR: begin
        hit_d = hit_q | fb_rdata;
        fb_we = 1'b1;
        fb_wdata = ~fb_rdata;
        col_d = col_q + 4'd1;
        state_d = S_DPIX;
      end
      default: state_d = S_IDLE;
    endcase

    if (fin_step) fin = 1'b1;
    if (fin) state_d = S_IDLE;
    if (reg_we) regv_d[reg_waddr] = 1'b1;
    if (cfg_we_i) lfsr_d = cfg_wdata_i;
  end

  // timers tick once per executed step
  always_comb begin
    dly_base = set_dt ? vx_q : dly_q;
    snd_base = set_st ? vx_q : snd_q;
    dly_d = dly_q;
    snd_d = snd_q;
    res_beep = 1'b0;
    if (fin_step) begin
      dly_d = dly_base - {7'd0, dly_base != 8'd0};
      snd_d = snd_base - {7'd0, snd_base != 8'd0};
      res_beep = snd_base == 8'd1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      pc_q <= PC_RESET;
      idx_q <= 16'd0;
      sp_q <= '0;
      dly_q <= 8'd0;
      snd_q <= 8'd0;
      lfsr_q <= SEED_RESET;
      halt_q <= 1'b0;
      clr_step_q <= 1'b0;
      clr_q <= '0;
      regv_q <= 16'd0;
      stkv_q <= '0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q <= pc_d;
      idx_q <= idx_d;
      sp_q <= sp_d;
      dly_q <= dly_d;
      snd_q <= snd_d;
      lfsr_q <= lfsr_d;
      halt_q <= halt_d;
      clr_step_q <= clr_step_d;
      clr_q <= clr_d;
      regv_q <= regv_d;
      stkv_q <= stkv_d;
      done_q <= fin;
    end
  end

  // payload and result registers
  always_ff @(posedge clk_i) begin
    op_q <= op_d;       ophi_q <= ophi_d;   vx_q <= vx_d;     vy_q <= vy_d;
    x0_q <= x0_d;       y0_q <= y0_d;       row_q <= row_d;   keys_q <= keys_d;
    i_q <= i_d;         col_q <= col_d;     hit_q <= hit_d;   flag_q <= flag_d;
    pix_ok_q <= pix_ok_d;
    p_q <= p_d;
    rraddr_q <= reg_raddr;
    sraddr_q <= stk_raddr;
    if (fin) begin
      res_pc_q <= pc_d;
      res_pix_q <= res_pix;
      res_chg_q <= res_chg;
      res_beep_q <= res_beep;
      res_wait_q <= res_wait;
      res_err_q <= halt_d;
    end
  end

  assign busy              = state_q != S_IDLE;
  assign done_o            = done_q;
  assign program_counter_o = res_pc_q;
  assign pixel_value_o     = res_pix_q;
  assign display_changed_o = res_chg_q;
  assign beep_o            = res_beep_q;
  assign waiting_for_key_o = res_wait_q;
  assign opcode_error_o    = res_err_q;

endmodule
